// ===== hdl/ntprb_pkg.sv =====
// ntprb_pkg: shared types and constants for the NTP reply builder.
// Used by every module under hdl; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntprb_pkg;

   localparam int ReplyWords = 12;
   localparam int WordIdxBits = $clog2(ReplyWords);
   localparam logic [WordIdxBits-1:0] LastWordIndex = WordIdxBits'(ReplyWords - 1);

   localparam logic [10:0] MinRequestBytes = 11'd48;

   localparam logic [2:0] ModeSymActive = 3'd1;
   localparam logic [2:0] ModeClient = 3'd3;
   localparam logic [2:0] ModeServer = 3'd4;
   localparam logic [2:0] VersionMin = 3'd1;
   localparam logic [2:0] VersionMax = 3'd4;

   localparam logic [1:0] LeapNone = 2'd0;
   localparam logic [1:0] LeapAlarm = 2'd3;

   localparam logic [7:0] StratumGps = 8'd1;
   localparam logic [7:0] StratumSntp = 8'd2;
   localparam logic [7:0] StratumRtc = 8'd12;
   localparam logic [7:0] StratumNone = 8'd16;

   localparam logic [7:0] PrecGpsPps = 8'hEC;
   localparam logic [7:0] PrecGps = 8'hEE;
   localparam logic [7:0] PrecRtc = 8'hF6;
   localparam logic [7:0] PrecCoarse = 8'hF9;

   localparam logic [31:0] DispGpsPps = 32'd5;
   localparam logic [31:0] DispGps = 32'd16;
   localparam logic [31:0] SntpShort = 32'h0000_1999;
   localparam logic [31:0] DispRtc = 32'd656;

   localparam logic [31:0] RefIdGps = 32'h4750_5300;
   localparam logic [31:0] RefIdRtc = 32'h5254_4300;

   localparam logic [31:0] EpochShift = 32'd2208988800;
   localparam logic [19:0] UsecMax = 20'd999999;

   // frac = floor(us * 2^26 / 15625) = (us * ceil(2^60 / 15625)) >> 34, exact for us < 1e6
   localparam logic [46:0] FracMagic = 47'd73786976294839;
   localparam logic [22:0] FracMagicHi = FracMagic[46:24];
   localparam logic [23:0] FracMagicLo = FracMagic[23:0];
   localparam int FracShift = 34;

   localparam int FifoDepth = 2;
   localparam int FifoPtrBits = $clog2(FifoDepth);
   localparam int FifoCntBits = $clog2(FifoDepth + 1);

   localparam logic [0:0] CsrPpsMode = 1'b0;

   typedef enum logic [1:0] {
      SRC_GPS,
      SRC_SNTP,
      SRC_RTC,
      SRC_NONE
   } src_type;

   typedef struct packed {
      logic [10:0] packet_len;
      logic [7:0] req_header;
      logic [7:0] req_poll;
      logic [63:0] client_tx_stamp;
      logic [2:0] sync_flags;
      logic [51:0] receive_time;
      logic [51:0] send_time;
      logic [51:0] fix_time;
      logic [31:0] upstream_ref_id;
   } req_item_type;

   typedef struct packed {
      logic [31:0] reply_word;
      logic [WordIdxBits-1:0] word_index;
      logic last_word;
      logic [31:0] served_count;
   } rsp_item_type;

   typedef struct packed {
      logic [ReplyWords-1:0][31:0] words;
      logic [31:0] served;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/ntprb_front.sv =====
// ntprb_front: request check, source select, header words and time conversion.
// Depends on ntprb_pkg; feeds ntprb_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ntprb_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic pps_mode,
   input wire logic push,
   output logic full,
   input wire ntprb_pkg::req_item_type req_item,
   output logic wr_en,
   output ntprb_pkg::entry_type wr_data,
   input wire logic fifo_full
);

   typedef struct packed {
      logic [3:0][31:0] head;
      logic [63:0] ctx;
      logic [31:0] ref_sec;
      logic [31:0] rx_sec;
      logic [31:0] tx_sec;
      logic [2:0][42:0] pp_hi;
      logic [2:0][43:0] pp_lo;
      logic [31:0] served;
   } stage_type;

   logic s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic [31:0] served_ff, served_in;

   logic accept, keep, s1_take;
   logic [2:0] mode, vn;
   ntprb_pkg::src_type src;
   logic [1:0] li;
   logic [7:0] stratum, prec;
   logic [31:0] delay, disp, refid;
   logic [51:0] refsrc;
   logic [2:0][51:0] stamps;
   logic [2:0][19:0] us;
   logic [2:0][31:0] frac;
   logic [2:0][66:0] prod;

   assign s1_take = s1_valid_ff && !fifo_full;
   assign full = s1_valid_ff && fifo_full;
   assign accept = push && !full;

   assign mode = req_item.req_header[2:0];
   assign vn = req_item.req_header[5:3];
   assign keep = (req_item.packet_len >= ntprb_pkg::MinRequestBytes)
      && (mode == ntprb_pkg::ModeSymActive || mode == ntprb_pkg::ModeClient)
      && (vn >= ntprb_pkg::VersionMin) && (vn <= ntprb_pkg::VersionMax);

   always_comb begin
      if (req_item.sync_flags[0]) begin
         src = ntprb_pkg::SRC_GPS;
      end else if (req_item.sync_flags[1]) begin
         src = ntprb_pkg::SRC_SNTP;
      end else if (req_item.sync_flags[2]) begin
         src = ntprb_pkg::SRC_RTC;
      end else begin
         src = ntprb_pkg::SRC_NONE;
      end
   end

   always_comb begin
      li = ntprb_pkg::LeapNone;
      delay = '0;
      disp = '0;
      refid = '0;
      stratum = ntprb_pkg::StratumNone;
      prec = ntprb_pkg::PrecCoarse;
      case (src)
         ntprb_pkg::SRC_GPS: begin
            stratum = ntprb_pkg::StratumGps;
            refid = ntprb_pkg::RefIdGps;
            prec = pps_mode ? ntprb_pkg::PrecGpsPps : ntprb_pkg::PrecGps;
            disp = pps_mode ? ntprb_pkg::DispGpsPps : ntprb_pkg::DispGps;
         end
         ntprb_pkg::SRC_SNTP: begin
            stratum = ntprb_pkg::StratumSntp;
            delay = ntprb_pkg::SntpShort;
            disp = ntprb_pkg::SntpShort;
            refid = req_item.upstream_ref_id;
         end
         ntprb_pkg::SRC_RTC: begin
            stratum = ntprb_pkg::StratumRtc;
            prec = ntprb_pkg::PrecRtc;
            disp = ntprb_pkg::DispRtc;
            refid = ntprb_pkg::RefIdRtc;
         end
         default: begin
            li = ntprb_pkg::LeapAlarm;
         end
      endcase
   end

   assign refsrc = (src == ntprb_pkg::SRC_GPS) ? req_item.fix_time : req_item.receive_time;
   assign stamps[0] = refsrc;
   assign stamps[1] = req_item.receive_time;
   assign stamps[2] = req_item.send_time;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         us[i] = (stamps[i][19:0] > ntprb_pkg::UsecMax) ? ntprb_pkg::UsecMax
                                                        : stamps[i][19:0];
      end
   end

   always_comb begin
      s1_in.head[0] = {li, vn, ntprb_pkg::ModeServer, stratum, req_item.req_poll, prec};
      s1_in.head[1] = delay;
      s1_in.head[2] = disp;
      s1_in.head[3] = refid;
      s1_in.ctx = req_item.client_tx_stamp;
      s1_in.ref_sec = stamps[0][51:20] + ntprb_pkg::EpochShift;
      s1_in.rx_sec = stamps[1][51:20] + ntprb_pkg::EpochShift;
      s1_in.tx_sec = stamps[2][51:20] + ntprb_pkg::EpochShift;
      for (int i = 0; i < 3; i++) begin
         s1_in.pp_hi[i] = 43'(us[i]) * 43'(ntprb_pkg::FracMagicHi);
         s1_in.pp_lo[i] = 44'(us[i]) * 44'(ntprb_pkg::FracMagicLo);
      end
      s1_in.served = served_ff + 32'd1;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_take;
      served_in = served_ff;
      if (accept && keep) begin
         s1_valid_in = 1'b1;
         served_in = served_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         served_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         served_ff <= served_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         s1_ff <= s1_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = {s1_ff.pp_hi[i], 24'd0} + 67'(s1_ff.pp_lo[i]);
         frac[i] = prod[i][ntprb_pkg::FracShift +: 32];
      end
   end

   assign wr_en = s1_take;

   always_comb begin
      wr_data.words[0] = s1_ff.head[0];
      wr_data.words[1] = s1_ff.head[1];
      wr_data.words[2] = s1_ff.head[2];
      wr_data.words[3] = s1_ff.head[3];
      wr_data.words[4] = s1_ff.ref_sec;
      wr_data.words[5] = frac[0];
      wr_data.words[6] = s1_ff.ctx[63:32];
      wr_data.words[7] = s1_ff.ctx[31:0];
      wr_data.words[8] = s1_ff.rx_sec;
      wr_data.words[9] = frac[1];
      wr_data.words[10] = s1_ff.tx_sec;
      wr_data.words[11] = frac[2];
      wr_data.served = s1_ff.served;
   end

endmodule

`default_nettype wire

// ===== hdl/ntprb_fifo.sv =====
// ntprb_fifo: short queue of finished replies between front and back.
// Depends on ntprb_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module ntprb_fifo (
   input wire logic clock,
   input wire logic reset,
   input wire logic wr_en,
   input wire ntprb_pkg::entry_type wr_data,
   output logic fifo_full,
   input wire logic rd_en,
   output ntprb_pkg::entry_type rd_data,
   output logic fifo_empty
);

   ntprb_pkg::entry_type mem [ntprb_pkg::FifoDepth];
   logic [ntprb_pkg::FifoPtrBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ntprb_pkg::FifoCntBits-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign fifo_full = (count_ff == ntprb_pkg::FifoCntBits'(ntprb_pkg::FifoDepth));
   assign fifo_empty = (count_ff == '0);
   assign do_wr = wr_en && !fifo_full;
   assign do_rd = rd_en && !fifo_empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == ntprb_pkg::FifoPtrBits'(ntprb_pkg::FifoDepth - 1))
            ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == ntprb_pkg::FifoPtrBits'(ntprb_pkg::FifoDepth - 1))
            ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ntprb_back.sv =====
// ntprb_back: holds one reply and streams its words out one per transfer.
// Depends on ntprb_pkg; pulls entries from ntprb_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ntprb_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic fifo_empty,
   input wire ntprb_pkg::entry_type rd_data,
   output logic rd_en,
   output logic empty,
   input wire logic pop,
   output ntprb_pkg::rsp_item_type rsp_item
);

   logic busy_ff, busy_in;
   logic [ntprb_pkg::WordIdxBits-1:0] idx_ff, idx_in;
   ntprb_pkg::entry_type cur_ff;
   logic is_last, take, load;

   assign is_last = (idx_ff == ntprb_pkg::LastWordIndex);
   assign take = busy_ff && pop;
   assign load = !fifo_empty && (!busy_ff || (take && is_last));
   assign rd_en = load;
   assign empty = !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in = '0;
      end else if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= rd_data;
      end
   end

   always_comb begin
      rsp_item.reply_word = cur_ff.words[idx_ff];
      rsp_item.word_index = idx_ff;
      rsp_item.last_word = is_last;
      rsp_item.served_count = cur_ff.served;
   end

endmodule

`default_nettype wire

// ===== hdl/ntp_reply_builder_top.sv =====
// NTP v4 server reply builder. A request is taken whenever full is low: requests that are
// too short or carry a bad mode or version vanish, the rest yield a 48-byte reply as twelve
// words, one per pop; a steady stream is paced by the result port as new requests queue
// up behind it. A taken request passes the front stage register, a queue of up to two
// finished replies and the back stage's reply register before its first word shows.
// pps_mode sits at APB byte address 0 and should be written while no reply is pending.
// Depends on ntprb_pkg, ntprb_front, ntprb_fifo and ntprb_back.
`timescale 1ns / 1ps
`default_nettype none

module ntp_reply_builder_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire ntprb_pkg::req_item_type req_item,
   output logic empty,
   input wire logic pop,
   output ntprb_pkg::rsp_item_type rsp_item,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [2:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   logic pps_mode_ff, pps_mode_in;
   logic csr_wr, csr_hit;
   logic wr_en, rd_en, fifo_full, fifo_empty;
   ntprb_pkg::entry_type wr_data, rd_data;

   assign pready = 1'b1;
   assign csr_hit = (paddr[2] == ntprb_pkg::CsrPpsMode);
   assign csr_wr = psel && penable && pwrite && csr_hit;
   assign pps_mode_in = csr_wr ? pwdata[0] : pps_mode_ff;
   assign prdata = csr_hit ? {31'd0, pps_mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pps_mode_ff <= 1'b0;
      end else begin
         pps_mode_ff <= pps_mode_in;
      end
   end

   ntprb_front u_front (
      .clock(clock),
      .reset(reset),
      .pps_mode(pps_mode_ff),
      .push(push),
      .full(full),
      .req_item(req_item),
      .wr_en(wr_en),
      .wr_data(wr_data),
      .fifo_full(fifo_full)
   );

   ntprb_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .wr_en(wr_en),
      .wr_data(wr_data),
      .fifo_full(fifo_full),
      .rd_en(rd_en),
      .rd_data(rd_data),
      .fifo_empty(fifo_empty)
   );

   ntprb_back u_back (
      .clock(clock),
      .reset(reset),
      .fifo_empty(fifo_empty),
      .rd_data(rd_data),
      .rd_en(rd_en),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for ntp_reply_builder_top.
// Predicts every reply word from the request fields, sync flags and pps_mode.
// Checks it against the result port. Depends on ntprb_pkg and the RTL under hdl.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [2:0] PPS_MODE_ADDR = 3'd0;
   localparam logic [2:0] SPARE_ADDR = 3'd4;
   localparam int RANDOM_REQUESTS = 460;
   localparam int DRAIN_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [31:0] NTP_EPOCH_OFFSET = 32'd2208988800;
   localparam logic [31:0] GPS_REFID = 32'h4750_5300;
   localparam logic [31:0] RTC_REFID = 32'h5254_4300;
   localparam logic [31:0] SNTP_ROOT = 32'h0000_1999;

   logic clock = 1'b0;
   logic reset;
   logic push;
   logic full;
   ntprb_pkg::req_item_type req_item;
   logic empty;
   logic pop;
   ntprb_pkg::rsp_item_type rsp_item;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   ntprb_pkg::rsp_item_type reply_words_due[$];
   logic [31:0] replies_served;
   logic pps_enabled;
   int errors;
   int gap_pct;
   int stall_pct;
   int pop_hold;
   int idle_cycles;
   logic [51:0] stamp_corners [5] = '{
      {32'h0000_0000, 20'd0},
      {32'hFFFF_FFFF, 20'hFFFFF},
      {32'h7FFF_FFFF, 20'd999999},
      {32'h8000_0000, 20'd1000000},
      {32'h1234_5678, 20'd1}
   };

   ntp_reply_builder_top uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_item(req_item),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] ntp_secs(logic [51:0] stamp);
      return stamp[51:20] + NTP_EPOCH_OFFSET;
   endfunction

   function automatic logic [31:0] ntp_frac(logic [51:0] stamp);
      logic [63:0] us;
      us = (stamp[19:0] > 20'd999999) ? 64'd999999 : 64'(stamp[19:0]);
      return 32'((us << 32) / 64'd1000000);
   endfunction

   function automatic bit request_served(ntprb_pkg::req_item_type r);
      logic [2:0] mode;
      logic [2:0] vn;
      mode = r.req_header[2:0];
      vn = r.req_header[5:3];
      return r.packet_len >= 11'd48 &&
         (mode == ntprb_pkg::ModeClient || mode == ntprb_pkg::ModeSymActive) &&
         vn >= ntprb_pkg::VersionMin && vn <= ntprb_pkg::VersionMax;
   endfunction

   task automatic predict_reply(input ntprb_pkg::req_item_type r);
      ntprb_pkg::src_type src;
      logic [1:0] li;
      logic [7:0] stratum;
      logic [7:0] prec;
      logic [31:0] delay;
      logic [31:0] disp;
      logic [31:0] refid;
      logic [51:0] ref_stamp;
      logic [31:0] words [12];
      ntprb_pkg::rsp_item_type w;
      if (!request_served(r))
         return;
      if (r.sync_flags[0])
         src = ntprb_pkg::SRC_GPS;
      else if (r.sync_flags[1])
         src = ntprb_pkg::SRC_SNTP;
      else if (r.sync_flags[2])
         src = ntprb_pkg::SRC_RTC;
      else
         src = ntprb_pkg::SRC_NONE;
      li = 2'd0;
      delay = '0;
      disp = '0;
      refid = '0;
      case (src)
         ntprb_pkg::SRC_GPS: begin
            stratum = 8'd1;
            prec = pps_enabled ? 8'hEC : 8'hEE;
            disp = pps_enabled ? 32'd5 : 32'd16;
            refid = GPS_REFID;
         end
         ntprb_pkg::SRC_SNTP: begin
            stratum = 8'd2;
            prec = 8'hF9;
            delay = SNTP_ROOT;
            disp = SNTP_ROOT;
            refid = r.upstream_ref_id;
         end
         ntprb_pkg::SRC_RTC: begin
            stratum = 8'd12;
            prec = 8'hF6;
            disp = 32'd656;
            refid = RTC_REFID;
         end
         default: begin
            li = 2'd3;
            stratum = 8'd16;
            prec = 8'hF9;
         end
      endcase
      ref_stamp = (src == ntprb_pkg::SRC_GPS) ? r.fix_time : r.receive_time;
      words[0] = {li, r.req_header[5:3], ntprb_pkg::ModeServer, stratum, r.req_poll, prec};
      words[1] = delay;
      words[2] = disp;
      words[3] = refid;
      words[4] = ntp_secs(ref_stamp);
      words[5] = ntp_frac(ref_stamp);
      words[6] = r.client_tx_stamp[63:32];
      words[7] = r.client_tx_stamp[31:0];
      words[8] = ntp_secs(r.receive_time);
      words[9] = ntp_frac(r.receive_time);
      words[10] = ntp_secs(r.send_time);
      words[11] = ntp_frac(r.send_time);
      replies_served = replies_served + 32'd1;
      for (int k = 0; k < 12; k++) begin
         w.reply_word = words[k];
         w.word_index = ntprb_pkg::WordIdxBits'(k);
         w.last_word = (k == 11);
         w.served_count = replies_served;
         reply_words_due.push_back(w);
      end
   endtask

   // checks every transfer on the result port
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (reply_words_due.size() == 0) begin
            $error("unexpected reply word %h", rsp_item.reply_word);
            errors++;
         end else begin
            ntprb_pkg::rsp_item_type want;
            want = reply_words_due.pop_front();
            if (rsp_item.reply_word !== want.reply_word) begin
               $error("reply_word exp %h got %h", want.reply_word, rsp_item.reply_word);
               errors++;
            end
            if (rsp_item.word_index !== want.word_index) begin
               $error("word_index exp %0d got %0d", want.word_index, rsp_item.word_index);
               errors++;
            end
            if (rsp_item.last_word !== want.last_word) begin
               $error("last_word exp %b got %b", want.last_word, rsp_item.last_word);
               errors++;
            end
            if (rsp_item.served_count !== want.served_count) begin
               $error("served_count exp %h got %h", want.served_count, rsp_item.served_count);
               errors++;
            end
         end
      end
   end

   // result-side stalls
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold--;
         pop <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         pop_hold = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic idle_gap();
      int n;
      n = 0;
      if ($urandom_range(99) < gap_pct)
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      if (n > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_request(input ntprb_pkg::req_item_type r);
      @(negedge clock);
      push <= 1'b1;
      req_item <= r;
      forever begin
         @(posedge clock);
         if (!full)
            break;
      end
      predict_reply(r);
      idle_gap();
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      push <= 1'b0;
      while (reply_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready)
            break;
      end
      if (addr == PPS_MODE_ADDR)
         pps_enabled = data[0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [2:0] addr, input logic [31:0] want);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready)
            break;
      end
      if (prdata !== want) begin
         $error("prdata exp %h got %h", want, prdata);
         errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [51:0] random_stamp();
      logic [19:0] us;
      us = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
      return {32'($urandom), us};
   endfunction

   function automatic ntprb_pkg::req_item_type noise_request();
      ntprb_pkg::req_item_type r;
      r.packet_len = 11'($urandom);
      r.req_header = 8'($urandom);
      r.req_poll = 8'($urandom);
      r.client_tx_stamp = {32'($urandom), 32'($urandom)};
      r.sync_flags = 3'($urandom);
      r.receive_time = random_stamp();
      r.send_time = random_stamp();
      r.fix_time = random_stamp();
      r.upstream_ref_id = 32'($urandom);
      return r;
   endfunction

   function automatic ntprb_pkg::req_item_type good_request();
      ntprb_pkg::req_item_type r;
      logic [2:0] mode;
      r = noise_request();
      mode = $urandom_range(1) ? ntprb_pkg::ModeClient : ntprb_pkg::ModeSymActive;
      r.packet_len = ($urandom_range(3) == 0) ? 11'($urandom_range(2047, 48)) :
         11'($urandom_range(100, 48));
      r.req_header = {2'($urandom), 3'($urandom_range(4, 1)), mode};
      return r;
   endfunction

   task automatic test_length_and_header();
      ntprb_pkg::req_item_type r;
      logic [2:0] bad_modes [6] = '{3'd0, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7};
      logic [2:0] bad_versions [4] = '{3'd0, 3'd5, 3'd6, 3'd7};
      r = good_request();
      r.packet_len = 11'd47;
      send_request(r);
      r.packet_len = 11'd0;
      send_request(r);
      r = good_request();
      r.packet_len = 11'd48;
      r.req_poll = 8'h00;
      r.client_tx_stamp = '0;
      r.req_header = {2'b00, 3'd4, ntprb_pkg::ModeClient};
      send_request(r);
      r = good_request();
      r.packet_len = 11'd2047;
      r.req_poll = 8'hFF;
      r.client_tx_stamp = '1;
      r.upstream_ref_id = '1;
      r.req_header = {2'b11, 3'd1, ntprb_pkg::ModeSymActive};
      send_request(r);
      foreach (bad_modes[i]) begin
         r = good_request();
         r.req_header[2:0] = bad_modes[i];
         send_request(r);
      end
      foreach (bad_versions[i]) begin
         r = good_request();
         r.req_header[5:3] = bad_versions[i];
         send_request(r);
      end
      for (int v = 2; v <= 3; v++) begin
         r = good_request();
         r.req_header[5:3] = 3'(v);
         send_request(r);
      end
   endtask

   task automatic test_time_sources();
      ntprb_pkg::req_item_type r;
      for (int f = 0; f < 8; f++) begin
         r = good_request();
         r.sync_flags = 3'(f);
         r.receive_time = stamp_corners[f % 5];
         r.send_time = stamp_corners[(f + 1) % 5];
         r.fix_time = stamp_corners[(f + 2) % 5];
         send_request(r);
      end
   endtask

   task automatic test_pps_mode();
      ntprb_pkg::req_item_type r;
      wait_for_replies();
      csr_write(PPS_MODE_ADDR, 32'hFFFF_FFFF);
      csr_read_check(PPS_MODE_ADDR, 32'd1);
      csr_write(SPARE_ADDR, 32'h0);
      csr_read_check(PPS_MODE_ADDR, 32'd1);
      for (int i = 0; i < 3; i++) begin
         r = good_request();
         r.sync_flags = 3'(1 + 2 * i);
         send_request(r);
      end
      wait_for_replies();
      csr_write(PPS_MODE_ADDR, 32'h0);
      csr_read_check(PPS_MODE_ADDR, 32'd0);
   endtask

   task automatic test_random_traffic();
      ntprb_pkg::req_item_type r;
      int phase_gap [4] = '{0, 30, 10, 60};
      int phase_stall [4] = '{0, 30, 60, 10};
      for (int p = 0; p < 4; p++) begin
         wait_for_replies();
         csr_write(PPS_MODE_ADDR, 32'(p % 2 == 0));
         gap_pct = phase_gap[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < RANDOM_REQUESTS / 4; n++) begin
            case ($urandom_range(9))
               8: begin
                  r = good_request();
                  case ($urandom_range(2))
                     0: r.packet_len = 11'($urandom_range(47));
                     1: r.req_header[2:0] = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 4));
                     default: r.req_header[5:3] = $urandom_range(1) ? 3'd0 :
                        3'($urandom_range(7, 5));
                  endcase
               end
               9: r = noise_request();
               default: r = good_request();
            endcase
            send_request(r);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      pop = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      replies_served = '0;
      pps_enabled = 1'b0;
      errors = 0;
      gap_pct = 20;
      stall_pct = 20;
      pop_hold = 0;
      idle_cycles = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_length_and_header();
      test_time_sources();
      test_pps_mode();
      test_random_traffic();
      wait_for_replies();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ntprb_pkg.sv
hdl/ntprb_front.sv
hdl/ntprb_fifo.sv
hdl/ntprb_back.sv
hdl/ntp_reply_builder_top.sv
tb/sv/tb_top.sv
